[design/fbp_pkg.sv]
package fbp_pkg;

  localparam int unsigned NUM_PIECES = 12;
  localparam int unsigned NUM_SIDE   = 6;

  localparam logic [7:0]  START_SQUARE = 8'd56;
  localparam logic [7:0]  RANK_STEP    = 8'd16;
  localparam logic [2:0]  FIELD_MAX    = 3'd7;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [6:0]  NO_SQUARE    = 7'h7F;
  localparam logic [3:0]  WHITE_INDEX  = 4'd12;
  localparam logic [3:0]  BLACK_INDEX  = 4'd13;
  localparam logic [3:0]  ALL_INDEX    = 4'd14;
  localparam logic [3:0]  SLOT_NONE    = 4'hF;

  localparam logic [2:0] FIELD_SIDE    = 3'd1;
  localparam logic [2:0] FIELD_CASTLE  = 3'd2;
  localparam logic [2:0] FIELD_PASSANT = 3'd3;
  localparam logic [2:0] FIELD_HALF    = 3'd4;
  localparam logic [2:0] FIELD_FULL    = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_W  = 8'h77;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_UC_K  = 8'h4B;
  localparam logic [7:0] CH_UC_Q  = 8'h51;
  localparam logic [7:0] CH_LC_K  = 8'h6B;
  localparam logic [7:0] CH_LC_Q  = 8'h71;

  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 112;
  localparam int unsigned TUSER_OUT_W = 4;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [NUM_PIECES-1:0][63:0] boards;
    logic                        side;
    logic [3:0]                  castle;
    logic [6:0]                  passant;
    logic [15:0]                 half;
    logic [15:0]                 full;
  } snap_t;

  function automatic logic [3:0] piece_slot(input logic [7:0] c);
    logic [3:0] s;
    unique case (c)
      8'h50:   s = 4'd0;
      8'h52:   s = 4'd1;
      8'h4E:   s = 4'd2;
      8'h42:   s = 4'd3;
      8'h51:   s = 4'd4;
      8'h4B:   s = 4'd5;
      8'h70:   s = 4'd6;
      8'h72:   s = 4'd7;
      8'h6E:   s = 4'd8;
      8'h62:   s = 4'd9;
      8'h71:   s = 4'd10;
      8'h6B:   s = 4'd11;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
    return (v > {4'd0, COUNT_MAX}) ? COUNT_MAX : v[15:0];
  endfunction

endpackage

[design/fbp_in_stage.sv]
module fbp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,   // char_in
  input  logic              s_tlast_i,
  input  logic              consume_i,
  output fbp_pkg::in_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       take;

  assign s_tready_o = !valid_q || consume_i;
  assign take       = s_tvalid_i && s_tready_o;
  assign valid_d    = take || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q   <= s_tdata_i;
      last_q <= s_tlast_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.ch    = ch_q;
  assign item_o.last  = last_q;

endmodule

[design/fbp_parse.sv]
module fbp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbp_pkg::in_item_t item_i,
  input  logic              consume_i,
  output fbp_pkg::snap_t    snap_o
);

  logic [fbp_pkg::NUM_PIECES-1:0][63:0] boards_q, boards_d;
  logic [7:0]  cursor_q, cursor_d;
  logic [2:0]  field_q, field_d;
  logic        side_q, side_d;
  logic [3:0]  castle_q, castle_d;
  logic [6:0]  passant_q, passant_d;
  logic [3:0]  pend_q, pend_d;
  logic [15:0] half_q, half_d;
  logic [15:0] full_q, full_d;

  logic [7:0]  c;
  logic        digit;
  logic [3:0]  dval;
  logic [3:0]  pend;
  logic [2:0]  col;
  logic [7:0]  rank;
  logic [3:0]  slot;
  logic [7:0]  fchar;

  always_comb begin
    c         = item_i.ch;
    digit     = (c >= fbp_pkg::CH_ZERO) && (c <= fbp_pkg::CH_NINE);
    fchar     = c - fbp_pkg::CH_ZERO;
    dval      = fchar[3:0];
    pend      = item_i.last ? 4'd0 : pend_q;
    col       = 3'(pend - 4'd1);
    rank      = c - fbp_pkg::CH_ONE;
    slot      = fbp_pkg::piece_slot(c);
    boards_d  = boards_q;
    cursor_d  = cursor_q;
    field_d   = field_q;
    side_d    = side_q;
    castle_d  = castle_q;
    passant_d = passant_q;
    pend_d    = 4'd0;
    half_d    = half_q;
    full_d    = full_q;

    if (pend != 4'd0 && digit) begin
      if (c >= fbp_pkg::CH_ONE && c <= fbp_pkg::CH_EIGHT) begin
        passant_d = {1'b0, rank[2:0], col};
      end else begin
        passant_d = fbp_pkg::NO_SQUARE;
      end
    end else begin
      if (field_q == 3'd0) begin
        if (digit) begin
          cursor_d = cursor_q + {4'd0, dval};
        end else if (c == fbp_pkg::CH_SLASH) begin
          cursor_d = cursor_q - fbp_pkg::RANK_STEP;
        end else begin
          if (slot != fbp_pkg::SLOT_NONE && cursor_q < 8'd64) begin
            boards_d[slot][cursor_q[5:0]] = 1'b1;
          end
          cursor_d = cursor_q + 8'd1;
        end
      end
      if (c == fbp_pkg::CH_SPACE && field_q < fbp_pkg::FIELD_MAX) begin
        field_d = field_q + 3'd1;
      end
      case (field_d)
        fbp_pkg::FIELD_SIDE: begin
          if (c == fbp_pkg::CH_LC_W) side_d = 1'b1;
          if (c == fbp_pkg::CH_LC_B) side_d = 1'b0;
        end
        fbp_pkg::FIELD_CASTLE: begin
          if (c == fbp_pkg::CH_UC_K) castle_d[0] = 1'b1;
          if (c == fbp_pkg::CH_UC_Q) castle_d[1] = 1'b1;
          if (c == fbp_pkg::CH_LC_K) castle_d[2] = 1'b1;
          if (c == fbp_pkg::CH_LC_Q) castle_d[3] = 1'b1;
          if (c == fbp_pkg::CH_DASH) castle_d = 4'd0;
        end
        fbp_pkg::FIELD_PASSANT: begin
          if (c == fbp_pkg::CH_DASH) passant_d = fbp_pkg::NO_SQUARE;
          if (c >= fbp_pkg::CH_LC_A && c <= fbp_pkg::CH_LC_H) begin
            pend_d = 4'(c - fbp_pkg::CH_LC_A) + 4'd1;
          end
        end
        fbp_pkg::FIELD_HALF: begin
          if (digit) half_d = fbp_pkg::add_digit(half_q, dval);
        end
        fbp_pkg::FIELD_FULL: begin
          if (digit) full_d = fbp_pkg::add_digit(full_q, dval);
        end
        default: begin
        end
      endcase
    end
  end

  assign snap_o.boards  = boards_d;
  assign snap_o.side    = side_d;
  assign snap_o.castle  = castle_d;
  assign snap_o.passant = passant_d;
  assign snap_o.half    = half_d;
  assign snap_o.full    = full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boards_q  <= '0;
      cursor_q  <= fbp_pkg::START_SQUARE;
      field_q   <= 3'd0;
      side_q    <= 1'b1;
      castle_q  <= 4'd0;
      passant_q <= fbp_pkg::NO_SQUARE;
      pend_q    <= 4'd0;
      half_q    <= 16'd0;
      full_q    <= 16'd0;
    end else if (consume_i) begin
      side_q    <= side_d;
      passant_q <= passant_d;
      if (item_i.last) begin
        boards_q <= '0;
        cursor_q <= fbp_pkg::START_SQUARE;
        field_q  <= 3'd0;
        castle_q <= 4'd0;
        pend_q   <= 4'd0;
        half_q   <= 16'd0;
        full_q   <= 16'd0;
      end else begin
        boards_q <= boards_d;
        cursor_q <= cursor_d;
        field_q  <= field_d;
        castle_q <= castle_d;
        pend_q   <= pend_d;
        half_q   <= half_d;
        full_q   <= full_d;
      end
    end
  end

endmodule

[design/fbp_drain.sv]
module fbp_drain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  fbp_pkg::snap_t                    snap_i,
  output logic                              free_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [fbp_pkg::TDATA_OUT_W-1:0]   m_tdata_o,
  output logic [fbp_pkg::TUSER_OUT_W-1:0]   m_tuser_o,
  output logic                              m_tlast_o
);

  fbp_pkg::snap_t snap_q;
  logic           busy_q, busy_d;
  logic [3:0]     idx_q, idx_d;
  logic           fire;
  logic           done;
  logic [63:0]    white;
  logic [63:0]    black;
  logic [63:0]    bits;

  assign fire   = busy_q && m_tready_i;
  assign done   = fire && (idx_q == fbp_pkg::ALL_INDEX);
  assign free_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (fire) begin
      idx_d = idx_q + 4'd1;
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
  end

  always_comb begin
    white = '0;
    black = '0;
    for (int i = 0; i < fbp_pkg::NUM_SIDE; i++) begin
      white = white | snap_q.boards[i];
      black = black | snap_q.boards[i + fbp_pkg::NUM_SIDE];
    end
    case (idx_q)
      fbp_pkg::WHITE_INDEX: bits = white;
      fbp_pkg::BLACK_INDEX: bits = black;
      fbp_pkg::ALL_INDEX:   bits = white | black;
      4'd15:                bits = white | black;
      default:              bits = snap_q.boards[idx_q];
    endcase
  end

  assign m_tvalid_o = busy_q;
  assign m_tuser_o  = idx_q;
  assign m_tlast_o  = (idx_q == fbp_pkg::ALL_INDEX);
  assign m_tdata_o  = {4'd0, snap_q.full, snap_q.half, snap_q.passant,
                       snap_q.castle, snap_q.side, bits};

endmodule

[design/fen_board_parser.sv]
// A final character is registered in the input stage, then loaded into the snapshot register,
// which shows its first result. Throughput: one character per cycle; the final character then
// drains fifteen results, one per cycle while m_tready_i is high, from the snapshot register
// while the next string is parsed. A second final character waits until that register is free.
// Reset (rst_ni low, asynchronous): boards cleared, cursor at a8, white to move, no en passant.
module fen_board_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [fbp_pkg::TDATA_IN_W-1:0]    s_tdata_i,   // [7:0] char_in
  input  logic                              s_tlast_i,   // end_of_string
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [63:0] board_bits, [64] white_to_move, [65] castle_white_king,
  // [66] castle_white_queen, [67] castle_black_king, [68] castle_black_queen,
  // [75:69] passant_square, [91:76] halfmove_count, [107:92] fullmove_count
  output logic [fbp_pkg::TDATA_OUT_W-1:0]   m_tdata_o,
  output logic [fbp_pkg::TUSER_OUT_W-1:0]   m_tuser_o,   // [3:0] board_index
  output logic                              m_tlast_o    // last_result
);

  fbp_pkg::in_item_t item;
  fbp_pkg::snap_t    snap;
  logic              consume;
  logic              drain_free;

  assign consume = item.valid && (!item.last || drain_free);

  fbp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .consume_i  (consume),
    .item_o     (item)
  );

  fbp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .consume_i (consume),
    .snap_o    (snap)
  );

  fbp_drain u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (consume && item.last),
    .snap_i     (snap),
    .free_o     (drain_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

[bench/tb_fen_board_parser.sv]
`timescale 1ns / 100ps

module tb_fen_board_parser;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_CHARS = 310;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam string       PIECE_LETTERS = "PRNBQKprnbqk";

  typedef struct {
    logic [3:0]  index;
    logic [63:0] bits;
    logic        side;
    logic [3:0]  rights;
    logic [6:0]  ep;
    logic [15:0] half;
    logic [15:0] full;
    logic        last;
  } board_result_t;

  class fen_scoreboard;
    logic [63:0]   boards[fbp_pkg::NUM_PIECES];
    logic [7:0]    cursor;
    logic [2:0]    field_no;
    logic          white_side;
    logic [3:0]    rights;
    logic [6:0]    ep_square;
    logic [3:0]    ep_file;
    logic [15:0]   half_clock;
    logic [15:0]   full_clock;
    board_result_t boards_due[$];
    int            errors;

    function new();
      clear_run();
      white_side = 1'b1;
      ep_square  = fbp_pkg::NO_SQUARE;
      errors     = 0;
    endfunction

    function void clear_run();
      foreach (boards[k]) boards[k] = '0;
      cursor     = fbp_pkg::START_SQUARE;
      field_no   = '0;
      rights     = '0;
      ep_file    = '0;
      half_clock = '0;
      full_clock = '0;
    endfunction

    function logic [15:0] count_step(logic [15:0] acc, logic [3:0] d);
      int unsigned v;
      v = acc * 10 + d;
      return (v > fbp_pkg::COUNT_MAX) ? fbp_pkg::COUNT_MAX : 16'(v);
    endfunction

    function int pending();
      return boards_due.size();
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic          digit;
      logic          consumed;
      logic [2:0]    col;
      int            slot;
      logic [63:0]   white;
      logic [63:0]   black;
      board_result_t r;
      digit    = (c >= fbp_pkg::CH_ZERO) && (c <= fbp_pkg::CH_NINE);
      consumed = 1'b0;
      if (last) ep_file = '0;
      // en-passant file waiting for its rank digit
      if (ep_file != 0) begin
        col     = 3'(ep_file - 1);
        ep_file = '0;
        if (digit) begin
          if (c >= fbp_pkg::CH_ONE && c <= fbp_pkg::CH_EIGHT)
            ep_square = 7'(col + 8 * (c - fbp_pkg::CH_ONE));
          else ep_square = fbp_pkg::NO_SQUARE;
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        if (field_no == 0) begin
          if (digit) begin
            cursor = cursor + (c - fbp_pkg::CH_ZERO);
          end else if (c == fbp_pkg::CH_SLASH) begin
            cursor = cursor - fbp_pkg::RANK_STEP;
          end else begin
            slot = -1;
            for (int k = 0; k < fbp_pkg::NUM_PIECES; k++) if (PIECE_LETTERS[k] == c) slot = k;
            if (slot >= 0 && cursor < 64) boards[slot][cursor[5:0]] = 1'b1;
            cursor = cursor + 8'd1;
          end
        end
        if (c == fbp_pkg::CH_SPACE && field_no < fbp_pkg::FIELD_MAX) field_no = field_no + 3'd1;
        case (field_no)
          fbp_pkg::FIELD_SIDE: begin
            if (c == fbp_pkg::CH_LC_W) white_side = 1'b1;
            if (c == fbp_pkg::CH_LC_B) white_side = 1'b0;
          end
          fbp_pkg::FIELD_CASTLE: begin
            if (c == fbp_pkg::CH_UC_K) rights[0] = 1'b1;
            if (c == fbp_pkg::CH_UC_Q) rights[1] = 1'b1;
            if (c == fbp_pkg::CH_LC_K) rights[2] = 1'b1;
            if (c == fbp_pkg::CH_LC_Q) rights[3] = 1'b1;
            if (c == fbp_pkg::CH_DASH) rights = '0;
          end
          fbp_pkg::FIELD_PASSANT: begin
            if (c == fbp_pkg::CH_DASH) ep_square = fbp_pkg::NO_SQUARE;
            if (c >= fbp_pkg::CH_LC_A && c <= fbp_pkg::CH_LC_H)
              ep_file = 4'(c - fbp_pkg::CH_LC_A + 1);
          end
          fbp_pkg::FIELD_HALF:
            if (digit) half_clock = count_step(half_clock, 4'(c - fbp_pkg::CH_ZERO));
          fbp_pkg::FIELD_FULL:
            if (digit) full_clock = count_step(full_clock, 4'(c - fbp_pkg::CH_ZERO));
          default: ;
        endcase
      end
      if (!last) return;
      ep_file = '0;
      white = '0;
      black = '0;
      for (int k = 0; k < fbp_pkg::NUM_SIDE; k++) begin
        white |= boards[k];
        black |= boards[k + fbp_pkg::NUM_SIDE];
      end
      for (int k = 0; k <= fbp_pkg::ALL_INDEX; k++) begin
        r.index = 4'(k);
        if (k < fbp_pkg::NUM_PIECES) r.bits = boards[k];
        else if (r.index == fbp_pkg::WHITE_INDEX) r.bits = white;
        else if (r.index == fbp_pkg::BLACK_INDEX) r.bits = black;
        else r.bits = white | black;
        r.side   = white_side;
        r.rights = rights;
        r.ep     = ep_square;
        r.half   = half_clock;
        r.full   = full_clock;
        r.last   = (r.index == fbp_pkg::ALL_INDEX);
        boards_due.push_back(r);
      end
      clear_run();
    endfunction

    function void diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [3:0] idx, logic [fbp_pkg::TDATA_OUT_W-1:0] data,
                               logic last);
      board_result_t w;
      if (boards_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual index %0d bits %h",
                 $time, idx, data[63:0]);
        errors++;
        return;
      end
      w = boards_due.pop_front();
      diff("board_index", w.index, idx);
      diff("board_bits", w.bits, data[63:0]);
      diff("white_to_move", w.side, data[64]);
      diff("castling", w.rights, data[68:65]);
      diff("passant_square", w.ep, data[75:69]);
      diff("halfmove_count", w.half, data[91:76]);
      diff("fullmove_count", w.full, data[107:92]);
      diff("tdata_pad", '0, data[fbp_pkg::TDATA_OUT_W-1:108]);
      diff("last_result", w.last, last);
    endfunction
  endclass

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            s_tvalid_i = 1'b0;
  logic                            s_tready_o;
  logic [fbp_pkg::TDATA_IN_W-1:0]  s_tdata_i  = '0;
  logic                            s_tlast_i  = 1'b0;
  logic                            m_tvalid_o;
  logic                            m_tready_i = 1'b0;
  logic [fbp_pkg::TDATA_OUT_W-1:0] m_tdata_o;
  logic [fbp_pkg::TUSER_OUT_W-1:0] m_tuser_o;
  logic                            m_tlast_o;

  fen_scoreboard sb = new();
  int unsigned   cycles = 0;
  int unsigned   sent = 0;
  logic          tx_burst = 1'b0;
  logic          rx_burst = 1'b0;

  fen_board_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) sb.note_char(s_tdata_i, s_tlast_i);
      if (m_tvalid_o && m_tready_i) sb.check_result(m_tuser_o, m_tdata_o, m_tlast_o);
    end
  end

  // result sink with random back-pressure
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= c;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic send_string(ref logic [7:0] q[$]);
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
    sent += q.size();
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    // let the monitor note the item accepted at this edge first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void add_str(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  initial begin
    logic [7:0] q[$];
    int         strings;
    int         nfields;
    int         filled;
    int         d;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every piece, black to move, all castling rights, ep on a8, saturating clock,
    // last four pieces fall off the board
    q = {};
    add_str(q, "PRNBQKprnbqk b KQkq a8 99999");
    send_string(q);
    // cursor off the top, dashes, ep letter on the final char
    q = {};
    add_str(q, "9/k - - h");
    send_string(q);
    wait_drained();

    strings = 0;
    while (sent < RANDOM_CHARS) begin
      q = {};
      strings++;
      if ($urandom_range(0, 4) < 2) begin
        nfields = ($urandom_range(0, 3) != 0) ? 6 : $urandom_range(1, 8);
        for (int rank = 0; rank < 8; rank++) begin
          filled = 0;
          while (filled < 8) begin
            if ($urandom_range(0, 3) == 0) begin
              d = $urandom_range(1, 8 - filled);
              q.push_back(fbp_pkg::CH_ZERO + 8'(d));
              filled += d;
            end else begin
              q.push_back(PIECE_LETTERS[$urandom_range(0, fbp_pkg::NUM_PIECES - 1)]);
              filled++;
            end
          end
          // malformed rank: extra square or skip
          if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) != 0)
              q.push_back(fbp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            else q.push_back(PIECE_LETTERS[$urandom_range(0, fbp_pkg::NUM_PIECES - 1)]);
          end
          if (rank < 7) q.push_back(fbp_pkg::CH_SLASH);
        end
        for (int f = 1; f < nfields; f++) begin
          q.push_back(fbp_pkg::CH_SPACE);
          case (3'(f))
            fbp_pkg::FIELD_SIDE:
              q.push_back(($urandom_range(0, 1) != 0) ? fbp_pkg::CH_LC_W : fbp_pkg::CH_LC_B);
            fbp_pkg::FIELD_CASTLE: begin
              if ($urandom_range(0, 3) == 0) begin
                q.push_back(fbp_pkg::CH_DASH);
              end else begin
                if ($urandom_range(0, 1) != 0) q.push_back(fbp_pkg::CH_UC_K);
                if ($urandom_range(0, 1) != 0) q.push_back(fbp_pkg::CH_UC_Q);
                if ($urandom_range(0, 1) != 0) q.push_back(fbp_pkg::CH_LC_K);
                if ($urandom_range(0, 1) != 0) q.push_back(fbp_pkg::CH_LC_Q);
              end
            end
            fbp_pkg::FIELD_PASSANT: begin
              if ($urandom_range(0, 2) == 0) begin
                q.push_back(fbp_pkg::CH_DASH);
              end else begin
                q.push_back(fbp_pkg::CH_LC_A + 8'($urandom_range(0, 7)));
                case ($urandom_range(0, 3))
                  0: q.push_back(fbp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                  1: q.push_back(fbp_pkg::CH_DASH);
                  default: q.push_back(($urandom_range(0, 1) != 0) ? fbp_pkg::CH_ZERO + 8'd3
                                                                  : fbp_pkg::CH_ZERO + 8'd6);
                endcase
              end
            end
            fbp_pkg::FIELD_HALF, fbp_pkg::FIELD_FULL: begin
              if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(5, 7))
                  q.push_back(fbp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
              end else begin
                add_str(q, $sformatf("%0d", $urandom_range(0, 150)));
              end
            end
            default: q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 4) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 4))
            0, 1: q.push_back(8'($urandom_range(0, 255)));
            2: q.push_back(fbp_pkg::CH_SPACE);
            3: q.push_back(fbp_pkg::CH_LC_A + 8'($urandom_range(0, 7)));
            default: q.push_back(fbp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          endcase
        end
      end
      send_string(q);
      if (strings == 4) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
